>>> hdl/flc_delta_line_decoder_assert.svh
// ---------------------------------------------------------------------------
// flc_delta_line_decoder_assert.svh
// Assertion macros used by the delta line decoder RTL.
// ---------------------------------------------------------------------------
`ifndef FLC_DELTA_LINE_DECODER_ASSERT_SVH
`define FLC_DELTA_LINE_DECODER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define FLCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define FLCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/flcd_pkg.sv
// ---------------------------------------------------------------------------
// flcd_pkg
// Types, constants and helpers for the FLC delta line decoder.
// ---------------------------------------------------------------------------
package flcd_pkg;

    // Largest frame dimension accepted for width and height
    localparam int MAX_DIM = 512;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);

    // Fixed field widths
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int LINE_W  = 16;
    localparam int ADDR_W  = 18;
    localparam int REPS_W  = 8;
    localparam int CFG_W   = 10;
    localparam int SPAN_W  = REPS_W + 1;
    localparam int END_W   = LINE_W + 1;

    // Configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(320);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(200);

    // Opcode word classes (top two bits)
    localparam logic [1:0] OP_PACKETS = 2'd0;
    localparam logic [1:0] OP_UNDEF   = 2'd1;
    localparam logic [1:0] OP_LAST    = 2'd2;
    localparam logic [1:0] OP_SKIP    = 2'd3;

    // Parser phase
    typedef enum logic [2:0] {
        PH_LC_LO = 3'd0,
        PH_LC_HI = 3'd1,
        PH_OP_LO = 3'd2,
        PH_OP_HI = 3'd3,
        PH_SKIP  = 3'd4,
        PH_COUNT = 3'd5,
        PH_W_LO  = 3'd6,
        PH_W_HI  = 3'd7
    } phase_t;

    // Write command kind
    typedef enum logic [1:0] {
        WK_NONE = 2'd0,
        WK_BYTE = 2'd1,
        WK_WORD = 2'd2
    } wk_t;

    // Write request as seen by the bounds/address unit
    typedef struct packed {
        wk_t                kind;
        logic [ADDR_W-1:0]  address;
        logic [WORD_W-1:0]  data;
        logic [REPS_W-1:0]  reps;
        logic               oof;
    } flcd_write_t;

    // One result item
    typedef struct packed {
        flcd_write_t        wr;
        logic               done;
    } flcd_result_t;

    // Clamp a raw dimension register to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == CFG_W'(0))
            r = DIM_W'(1);
        else if (v > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        else
            r = DIM_W'(v);
        return r;
    endfunction

endpackage

>>> hdl/flcd_emit.sv
// ---------------------------------------------------------------------------
// flcd_emit
// Address and frame-bounds check for one write request.
// ---------------------------------------------------------------------------
module flcd_emit
    import flcd_pkg::*;
(
    input  logic [LINE_W-1:0] line,
    input  logic [LINE_W-1:0] col,
    input  logic [SPAN_W-1:0] span,
    input  wk_t               kind,
    input  logic [WORD_W-1:0] data,
    input  logic [REPS_W-1:0] reps,
    input  logic [DIM_W-1:0]  width_sat,
    input  logic [DIM_W-1:0]  height_sat,
    output flcd_write_t       wr
);

    logic [LINE_W+DIM_W-1:0] line_base;
    logic [END_W-1:0]        col_end;
    logic                    in_frame;

    // line * width + column, kept to the address width
    assign line_base = line * width_sat;

    // Line must be below the height and the span must end within the line
    assign col_end  = END_W'(col) + END_W'(span);
    assign in_frame = (line < LINE_W'(height_sat)) && (col_end <= END_W'(width_sat));

    always_comb
    begin
        wr.kind    = in_frame ? kind : WK_NONE;
        wr.address = ADDR_W'(line_base) + ADDR_W'(col);
        wr.data    = data;
        wr.reps    = reps;
        wr.oof     = !in_frame;
    end

endmodule

>>> hdl/flc_delta_line_decoder.sv
// ---------------------------------------------------------------------------
// flc_delta_line_decoder
// SS2 delta chunk parser producing frame-buffer write commands.
// ---------------------------------------------------------------------------
// Takes one chunk byte per item and can accept a byte in every clock cycle
// while in_stall is low. Parser state updates in the accepting cycle; a byte
// that produces a write or ends the chunk yields one result item through the
// result register. A second result register (skid) absorbs one item while the
// output is stalled, so in_stall rises only when both are full. Bytes after
// the chunk ends are ignored until chunk_start marks a new chunk. frame_width
// and frame_height are clamped to 1..512; writes outside the frame come out
// with write_kind 0 and out_of_frame set. Configuration is always ready.
// ---------------------------------------------------------------------------
`include "flc_delta_line_decoder_assert.svh"

module flc_delta_line_decoder
    import flcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    // input items
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic                 chunk_start,

    // result items
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           write_kind,
    output logic [ADDR_W-1:0]    write_address,
    output logic [WORD_W-1:0]    write_data,
    output logic [REPS_W-1:0]    repeat_words,
    output logic                 out_of_frame,
    output logic                 chunk_done
);

    // configuration registers
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [DIM_W-1:0]  width_sat;
    logic [DIM_W-1:0]  height_sat;

    // parser state
    phase_t            phase_reg,   phase_next;
    logic [BYTE_W-1:0] held_reg,    held_next;
    logic [LINE_W-1:0] lines_reg,   lines_next;
    logic [LINE_W-1:0] line_reg,    line_next;
    logic [LINE_W-1:0] packets_reg, packets_next;
    logic [LINE_W-1:0] column_reg,  column_next;
    logic [REPS_W-1:0] lit_reg,     lit_next;
    logic [REPS_W-1:0] rep_reg,     rep_next;
    logic              fin_reg,     fin_next;

    // state as seen by this byte (after an optional restart)
    phase_t            e_phase;
    logic [BYTE_W-1:0] e_held;
    logic [LINE_W-1:0] e_lines;
    logic [LINE_W-1:0] e_line;
    logic [LINE_W-1:0] e_packets;
    logic [LINE_W-1:0] e_column;
    logic [REPS_W-1:0] e_lit;
    logic [REPS_W-1:0] e_rep;
    logic              e_fin;

    // write request
    logic [LINE_W-1:0] em_col;
    logic [SPAN_W-1:0] em_span;
    wk_t               em_kind;
    logic [WORD_W-1:0] em_data;
    logic [REPS_W-1:0] em_reps;
    flcd_write_t       em_wr;

    logic              res_write;
    logic              res_done;
    logic              res_valid;
    flcd_result_t      res;

    // output stage
    flcd_result_t      out_reg;
    logic              out_valid_reg;
    flcd_result_t      skid_reg;
    logic              skid_valid_reg;

    logic              in_acc;
    logic              out_take;
    logic [WORD_W-1:0] op_word;
    logic [1:0]        op_code;
    logic [LINE_W-1:0] packets_dec;
    logic [LINE_W-1:0] lines_dec;
    logic [REPS_W-1:0] lit_dec;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_acc    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    assign width_sat  = sat_dim(width_reg);
    assign height_sat = sat_dim(height_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // restart view of the state
    always_comb
    begin
        if (chunk_start)
        begin
            e_phase   = PH_LC_LO;
            e_held    = '0;
            e_lines   = '0;
            e_line    = '0;
            e_packets = '0;
            e_column  = '0;
            e_lit     = '0;
            e_rep     = '0;
            e_fin     = 1'b0;
        end
        else
        begin
            e_phase   = phase_reg;
            e_held    = held_reg;
            e_lines   = lines_reg;
            e_line    = line_reg;
            e_packets = packets_reg;
            e_column  = column_reg;
            e_lit     = lit_reg;
            e_rep     = rep_reg;
            e_fin     = fin_reg;
        end
    end

    assign op_word     = {data_byte, e_held};
    assign op_code     = op_word[WORD_W-1 -: 2];
    assign packets_dec = e_packets - LINE_W'(1);
    assign lines_dec   = e_lines - LINE_W'(1);
    assign lit_dec     = e_lit - REPS_W'(1);

    // parser: next state and write request
    always_comb
    begin
        phase_next   = e_phase;
        held_next    = e_held;
        lines_next   = e_lines;
        line_next    = e_line;
        packets_next = e_packets;
        column_next  = e_column;
        lit_next     = e_lit;
        rep_next     = e_rep;
        fin_next     = e_fin;
        res_write    = 1'b0;
        res_done     = 1'b0;
        em_col       = e_column;
        em_span      = SPAN_W'(2);
        em_kind      = WK_WORD;
        em_data      = op_word;
        em_reps      = REPS_W'(1);

        if (!e_fin)
        begin
            unique case (e_phase)
                PH_LC_LO:
                begin
                    held_next  = data_byte;
                    phase_next = PH_LC_HI;
                end
                PH_LC_HI:
                begin
                    lines_next = op_word;
                    if (op_word == '0)
                    begin
                        fin_next = 1'b1;
                        res_done = 1'b1;
                    end
                    else
                        phase_next = PH_OP_LO;
                end
                PH_OP_LO:
                begin
                    held_next  = data_byte;
                    phase_next = PH_OP_HI;
                end
                PH_OP_HI:
                begin
                    phase_next = PH_OP_LO;
                    case (op_code)
                        OP_SKIP:
                            line_next = e_line - op_word;
                        OP_LAST:
                        begin
                            // single byte at the last pixel of the line
                            res_write = 1'b1;
                            em_kind   = WK_BYTE;
                            em_col    = LINE_W'(width_sat - DIM_W'(1));
                            em_span   = SPAN_W'(1);
                            em_data   = WORD_W'(op_word[BYTE_W-1:0]);
                        end
                        OP_PACKETS:
                        begin
                            packets_next = op_word;
                            column_next  = '0;
                            if (op_word == '0)
                            begin
                                // empty line
                                line_next  = e_line + LINE_W'(1);
                                lines_next = lines_dec;
                                if (lines_dec == '0)
                                begin
                                    fin_next = 1'b1;
                                    res_done = 1'b1;
                                end
                            end
                            else
                                phase_next = PH_SKIP;
                        end
                        default: ;
                    endcase
                end
                PH_SKIP:
                begin
                    column_next = e_column + LINE_W'(data_byte);
                    phase_next  = PH_COUNT;
                end
                PH_COUNT:
                begin
                    if (data_byte == '0)
                    begin
                        fin_next = 1'b1;
                        res_done = 1'b1;
                    end
                    else if (!data_byte[BYTE_W-1])
                    begin
                        lit_next   = data_byte;
                        rep_next   = '0;
                        phase_next = PH_W_LO;
                    end
                    else
                    begin
                        lit_next   = '0;
                        rep_next   = REPS_W'(-data_byte);
                        phase_next = PH_W_LO;
                    end
                end
                PH_W_LO:
                begin
                    held_next  = data_byte;
                    phase_next = PH_W_HI;
                end
                PH_W_HI:
                begin
                    res_write = 1'b1;
                    if (e_rep != '0)
                    begin
                        // repeated word run, ends the packet
                        em_span     = {e_rep, 1'b0};
                        em_reps     = e_rep;
                        column_next = e_column + LINE_W'({e_rep, 1'b0});
                        rep_next    = '0;
                    end
                    else
                    begin
                        column_next = e_column + LINE_W'(2);
                        lit_next    = lit_dec;
                    end

                    if (e_rep == '0 && lit_dec != '0)
                        phase_next = PH_W_LO;
                    else
                    begin
                        // packet finished
                        packets_next = packets_dec;
                        if (packets_dec != '0)
                            phase_next = PH_SKIP;
                        else
                        begin
                            line_next  = e_line + LINE_W'(1);
                            lines_next = lines_dec;
                            phase_next = PH_OP_LO;
                            if (lines_dec == '0)
                            begin
                                fin_next = 1'b1;
                                res_done = 1'b1;
                            end
                        end
                    end
                end
            endcase
        end
    end

    flcd_emit u_emit (
        .line       (e_line),
        .col        (em_col),
        .span       (em_span),
        .kind       (em_kind),
        .data       (em_data),
        .reps       (em_reps),
        .width_sat  (width_sat),
        .height_sat (height_sat),
        .wr         (em_wr)
    );

    // result item: fields stay zero with no write request
    always_comb
    begin
        res.wr   = res_write ? em_wr : '0;
        res.done = res_done;
    end
    assign res_valid = in_acc && (res_write || res_done);

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LC_LO;
            held_reg    <= '0;
            lines_reg   <= '0;
            line_reg    <= '0;
            packets_reg <= '0;
            column_reg  <= '0;
            lit_reg     <= '0;
            rep_reg     <= '0;
            fin_reg     <= 1'b1;
        end
        else if (in_acc)
        begin
            phase_reg   <= phase_next;
            held_reg    <= held_next;
            lines_reg   <= lines_next;
            line_reg    <= line_next;
            packets_reg <= packets_next;
            column_reg  <= column_next;
            lit_reg     <= lit_next;
            rep_reg     <= rep_next;
            fin_reg     <= fin_next;
        end
    end

    // result register and skid: valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
            out_valid_reg <= res_valid;
        else if (res_valid)
            skid_valid_reg <= 1'b1;
    end

    // result register and skid: payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (!out_valid_reg || out_take)
            out_reg <= res;
        else if (res_valid)
            skid_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign write_kind    = out_reg.wr.kind;
    assign write_address = out_reg.wr.address;
    assign write_data    = out_reg.wr.data;
    assign repeat_words  = out_reg.wr.reps;
    assign out_of_frame  = out_reg.wr.oof;
    assign chunk_done    = out_reg.done;

    // checks
    `FLCD_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full, result empty")
    `FLCD_ASSERT_NOW(a_drop_no_kind, out_valid_reg && out_reg.wr.oof, out_reg.wr.kind == WK_NONE, "dropped write has a kind")
    `FLCD_ASSERT_NOW(a_write_reps, out_valid_reg && out_reg.wr.kind != WK_NONE, out_reg.wr.reps != '0, "write with no words")
    `FLCD_ASSERT_NEXT(a_idle_holds, fin_reg && !(in_acc && chunk_start), fin_reg, "left idle without chunk start")

endmodule

>>> bench/tb_flc_delta_line_decoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_flc_delta_line_decoder
// Self-checking bench for the SS2 delta chunk decoder.
// ---------------------------------------------------------------------------
// A queue of chunk bytes feeds a clocked driver; a clocked monitor compares
// every write command with the oldest prediction from a bit-accurate decoder
// model kept here. A short directed chunk covers the opcode classes, the idle,
// zero line count and zero packet count cases. Random phases then run with
// different frame sizes, mostly well-formed chunks with random content plus
// truncated chunks and raw noise. Both sides idle in random bursts; the frame
// size is changed only once the decoder has drained.
// ---------------------------------------------------------------------------
module tb_flc_delta_line_decoder;
    import flcd_pkg::*;

    typedef struct {
        logic [BYTE_W-1:0] b;
        logic              start;
    } feed_item_t;

    localparam int NUM_PHASES   = 6;
    localparam int PHASE_BYTES  = 192;
    localparam int DRAIN_CYCLES = 6;

    // Directed chunk bytes, bit 8 = chunk_start
    localparam logic [8:0] DIRECTED_SEQ [25] = '{
        9'h055,                         // ignored while idle
        9'h100, 9'h000,                 // zero line count
        9'h102, 9'h000,                 // two lines
        9'h0FF, 9'h0FF,                 // skip one line
        9'h0AB, 9'h080,                 // last pixel byte
        9'h0FF, 9'h07F,                 // undefined code
        9'h000, 9'h000,                 // no packets, line ends
        9'h003, 9'h000,                 // three packets
        9'h000, 9'h001, 9'h0FF, 9'h0FF, // literal word
        9'h0FF, 9'h080, 9'h034, 9'h012, // 128-word run
        9'h000, 9'h000                  // zero count ends chunk
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    data_byte = '0;
    logic                 chunk_start = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           write_kind;
    logic [ADDR_W-1:0]    write_address;
    logic [WORD_W-1:0]    write_data;
    logic [REPS_W-1:0]    repeat_words;
    logic                 out_of_frame;
    logic                 chunk_done;

    flc_delta_line_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .chunk_start   (chunk_start),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_kind    (write_kind),
        .write_address (write_address),
        .write_data    (write_data),
        .repeat_words  (repeat_words),
        .out_of_frame  (out_of_frame),
        .chunk_done    (chunk_done)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    feed_item_t   byte_q[$];
    feed_item_t   chunk_q[$];
    flcd_result_t expected_writes[$];
    int           mismatches = 0;
    int           send_gap = 0;
    int           recv_gap = 0;
    bit           idle_on = 1'b1;
    bit           quiet = 1'b0;

    // Decoder model state
    logic [CFG_W-1:0]  frame_w_reg = FRAME_WIDTH_RST;
    logic [CFG_W-1:0]  frame_h_reg = FRAME_HEIGHT_RST;
    phase_t            pst = PH_LC_LO;
    logic [BYTE_W-1:0] low_hold = '0;
    logic [15:0]       lines_rem = '0;
    logic [15:0]       line_no = '0;
    logic [15:0]       pkts_rem = '0;
    logic [15:0]       col = '0;
    logic [7:0]        lits_rem = '0;
    logic [7:0]        run_len = '0;
    bit                parked = 1'b1;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    // Build a write command; span is in bytes
    function automatic flcd_write_t make_write(input wk_t kind, input int unsigned c,
                                               input int unsigned span,
                                               input logic [15:0] data,
                                               input logic [7:0] reps);
        flcd_write_t  w;
        int unsigned  fw;
        int unsigned  fh;
        bit           in_frame;
        fw = clamp_dim(frame_w_reg);
        fh = clamp_dim(frame_h_reg);
        in_frame = (32'(line_no) < fh) && (c + span <= fw);
        w.kind    = in_frame ? kind : WK_NONE;
        w.address = ADDR_W'(32'(line_no) * fw + c);
        w.data    = data;
        w.reps    = reps;
        w.oof     = !in_frame;
        return w;
    endfunction

    function automatic bit finish_line();
        line_no   = line_no + 16'd1;
        lines_rem = lines_rem - 16'd1;
        if (lines_rem == '0)
        begin
            parked = 1'b1;
            return 1'b1;
        end
        pst = PH_OP_LO;
        return 1'b0;
    endfunction

    function automatic bit finish_packet();
        pkts_rem = pkts_rem - 16'd1;
        if (pkts_rem != '0)
        begin
            pst = PH_SKIP;
            return 1'b0;
        end
        return finish_line();
    endfunction

    // Advance the model by one byte; returns 1 when a result item is due
    function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                       output flcd_result_t r);
        logic [15:0] op;
        logic [15:0] word;
        bit          wrote;
        bit          done;
        r     = '0;
        wrote = 1'b0;
        done  = 1'b0;
        if (start)
        begin
            pst       = PH_LC_LO;
            low_hold  = '0;
            lines_rem = '0;
            line_no   = '0;
            pkts_rem  = '0;
            col       = '0;
            lits_rem  = '0;
            run_len   = '0;
            parked    = 1'b0;
        end
        if (parked)
            return 1'b0;
        case (pst)
            PH_LC_LO:
            begin
                low_hold = b;
                pst = PH_LC_HI;
            end
            PH_LC_HI:
            begin
                lines_rem = {b, low_hold};
                if (lines_rem == '0)
                begin
                    parked = 1'b1;
                    done = 1'b1;
                end
                else
                    pst = PH_OP_LO;
            end
            PH_OP_LO:
            begin
                low_hold = b;
                pst = PH_OP_HI;
            end
            PH_OP_HI:
            begin
                op = {b, low_hold};
                pst = PH_OP_LO;
                case (op[15:14])
                    OP_SKIP:
                        line_no = line_no - op;
                    OP_LAST:
                    begin
                        r.wr = make_write(WK_BYTE, clamp_dim(frame_w_reg) - 1, 1,
                                          {8'h00, op[7:0]}, 8'd1);
                        wrote = 1'b1;
                    end
                    OP_PACKETS:
                    begin
                        pkts_rem = op;
                        col = '0;
                        if (op == '0)
                            done = finish_line();
                        else
                            pst = PH_SKIP;
                    end
                    default: ;
                endcase
            end
            PH_SKIP:
            begin
                col = col + 16'(b);
                pst = PH_COUNT;
            end
            PH_COUNT:
            begin
                if (b == '0)
                begin
                    parked = 1'b1;
                    done = 1'b1;
                end
                else if (!b[7])
                begin
                    lits_rem = b;
                    run_len = '0;
                    pst = PH_W_LO;
                end
                else
                begin
                    lits_rem = '0;
                    run_len = 8'(9'h100 - 9'(b));
                    pst = PH_W_LO;
                end
            end
            PH_W_LO:
            begin
                low_hold = b;
                pst = PH_W_HI;
            end
            default:
            begin
                word = {b, low_hold};
                wrote = 1'b1;
                if (run_len != '0)
                begin
                    r.wr = make_write(WK_WORD, col, 2 * int'(run_len), word, run_len);
                    col = col + 16'(2 * int'(run_len));
                    run_len = '0;
                    done = finish_packet();
                end
                else
                begin
                    r.wr = make_write(WK_WORD, col, 2, word, 8'd1);
                    col = col + 16'd2;
                    lits_rem = lits_rem - 8'd1;
                    if (lits_rem != '0)
                        pst = PH_W_LO;
                    else
                        done = finish_packet();
                end
            end
        endcase
        r.done = done;
        return wrote || done;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Byte driver: predicts on acceptance, then picks the next item or a gap
    always @(posedge clk)
    begin : drive
        flcd_result_t res;
        feed_item_t   it;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (decode_byte(data_byte, chunk_start, res))
                    expected_writes.push_back(res);
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (idle_on && !quiet && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(1, 15) - 1;
                    in_valid <= 1'b0;
                end
                else if (byte_q.size() > 0)
                begin
                    it = byte_q.pop_front();
                    in_valid    <= 1'b1;
                    data_byte   <= it.b;
                    chunk_start <= it.start;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random output stalls
    always @(posedge clk)
    begin : watch
        flcd_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_writes.size() == 0)
                    report_mismatch("unexpected result item", 1, 0);
                else
                begin
                    want = expected_writes.pop_front();
                    if (write_kind !== want.wr.kind)
                        report_mismatch("write_kind", write_kind, want.wr.kind);
                    if (write_address !== want.wr.address)
                        report_mismatch("write_address", write_address, want.wr.address);
                    if (write_data !== want.wr.data)
                        report_mismatch("write_data", write_data, want.wr.data);
                    if (repeat_words !== want.wr.reps)
                        report_mismatch("repeat_words", repeat_words, want.wr.reps);
                    if (out_of_frame !== want.wr.oof)
                        report_mismatch("out_of_frame", out_of_frame, want.wr.oof);
                    if (chunk_done !== want.done)
                        report_mismatch("chunk_done", chunk_done, want.done);
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else if (idle_on && !quiet && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(1, 15) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_FRAME_WIDTH)
            frame_w_reg = val;
        else
            frame_h_reg = val;
    endtask

    // Hold the sender until every predicted result has come out
    task automatic drain();
        while (byte_q.size() != 0 || in_valid || expected_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_byte(input logic [7:0] b, input logic s);
        feed_item_t it;
        it.b = b;
        it.start = s;
        chunk_q.push_back(it);
    endtask

    task automatic add_word(input logic [15:0] w);
        add_byte(w[7:0], 1'b0);
        add_byte(w[15:8], 1'b0);
    endtask

    // Well-formed chunk with random content into chunk_q
    task automatic build_chunk();
        int          nlines;
        int          nops;
        int          npk;
        int          cnt;
        logic [15:0] op;
        nlines = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
        add_byte(8'(nlines), 1'b1);
        add_byte(8'(nlines >> 8), 1'b0);
        for (int ln = 0; ln < nlines; ln++)
        begin
            nops = $urandom_range(0, 2);
            for (int k = 0; k < nops; k++)
            begin
                case ($urandom_range(0, 2))
                    0: op = ($urandom_range(0, 3) != 0) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                                         : 16'hC000 | 16'($urandom_range(0, 16383));
                    1: op = 16'h8000 | 16'($urandom_range(0, 16383));
                    default: op = 16'h4000 | 16'($urandom_range(0, 16383));
                endcase
                add_word(op);
            end
            npk = $urandom_range(0, 3);
            add_word(16'(npk));
            for (int p = 0; p < npk; p++)
            begin
                add_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 40)), 1'b0);
                case ($urandom_range(0, 39)) inside
                    0:
                    begin
                        add_byte(8'h00, 1'b0);
                        return;
                    end
                    1: cnt = 127;
                    2: cnt = -128;
                    [3:19]:
                        cnt = -$urandom_range(1, 8);
                    default: cnt = $urandom_range(1, 4);
                endcase
                add_byte(8'(cnt), 1'b0);
                if (cnt > 0)
                begin
                    for (int k = 0; k < cnt; k++)
                        add_word(16'($urandom_range(0, 65535)));
                end
                else
                    add_word(16'($urandom_range(0, 65535)));
            end
        end
    endtask

    // Random stimulus: chunks, truncated chunks, noise
    task automatic queue_random(input int budget);
        int added;
        int keep;
        int n;
        added = 0;
        while (added < budget)
        begin
            chunk_q.delete();
            if ($urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 12);
                for (int k = 0; k < n; k++)
                    add_byte(8'($urandom_range(0, 255)),
                             (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0));
            end
            else
            begin
                build_chunk();
                if ($urandom_range(0, 9) == 0)
                begin
                    keep = $urandom_range(1, chunk_q.size());
                    while (chunk_q.size() > keep)
                        void'(chunk_q.pop_back());
                end
            end
            added += chunk_q.size();
            foreach (chunk_q[k])
                byte_q.push_back(chunk_q[k]);
            // trailing bytes with no chunk start: ignored or noise
            if ($urandom_range(0, 7) == 0)
                for (int k = 0; k < 2; k++)
                begin
                    chunk_q[0].b = 8'($urandom_range(0, 255));
                    chunk_q[0].start = 1'b0;
                    byte_q.push_back(chunk_q[0]);
                end
        end
    endtask

    // Run control
    initial
    begin
        logic [CFG_W-1:0] fw;
        logic [CFG_W-1:0] fh;
        feed_item_t       it;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed chunk at reset frame size
        foreach (DIRECTED_SEQ[k])
        begin
            it.b = DIRECTED_SEQ[k][7:0];
            it.start = DIRECTED_SEQ[k][8];
            byte_q.push_back(it);
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    fw = 10'd1;
                    fh = 10'd1;
                end
                1:
                begin
                    fw = 10'd512;
                    fh = 10'd512;
                end
                2:
                begin
                    fw = 10'd0;
                    fh = 10'd1023;
                end
                3:
                begin
                    fw = 10'd1023;
                    fh = 10'd0;
                end
                4:
                begin
                    fw = 10'($urandom_range(1, 64));
                    fh = 10'($urandom_range(1, 8));
                end
                default:
                begin
                    fw = 10'($urandom_range(1, 1023));
                    fh = 10'($urandom_range(1, 1023));
                end
            endcase
            write_reg(CFG_FRAME_WIDTH, fw);
            write_reg(CFG_FRAME_HEIGHT, fh);
            idle_on = ($urandom_range(0, 3) != 0);
            quiet = (p == NUM_PHASES - 1);
            queue_random(PHASE_BYTES);
            drain();
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
